/* rtl/msm_pkg.sv */
// Package for the median-of-three adaptive smoother: widths, register indexes,
// the shared-unit operation codes, the sequencer states and the interface structs.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package msm_pkg;

  // Fractional bits of the distance format (Q9.FRAC_BITS centimetres).
  localparam int FRAC_BITS = 8;

  localparam int ECHO_W  = 15;
  localparam int SCALE_W = 16;
  localparam int THR_W   = 8;
  localparam int GAIN_W  = 9;
  localparam int OUT_W   = 17;
  localparam int DIST_W  = 9 + FRAC_BITS;
  localparam int DINT_W  = DIST_W - FRAC_BITS;

  // The scale register is Q0.16, the gains are Q1.8.
  localparam int SCALE_SH = SCALE_W - FRAC_BITS;
  localparam int GAIN_SH  = 8;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(256);

  // Operand width of the shared unit: wide enough for the scale and a distance.
  localparam int OP_W  = (DIST_W > SCALE_W) ? DIST_W : SCALE_W;
  localparam int RES_W = 2 * OP_W;

  localparam int IN_TDATA_W  = ((ECHO_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FAST_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAIN = CFG_IDX_W'(3);

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1140);
  localparam logic [THR_W-1:0]   THR_RST   = THR_W'(1);
  localparam logic [GAIN_W-1:0]  FAST_RST  = GAIN_W'(179);
  localparam logic [GAIN_W-1:0]  SLOW_RST  = GAIN_W'(26);

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_ADD = 2'd1,
    ALU_SUB = 2'd2
  } alu_op_e;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_MUL   = 13'b0000000000010,
    ST_WR    = 13'b0000000000100,
    ST_CXY   = 13'b0000000001000,
    ST_CXZ   = 13'b0000000010000,
    ST_CYZ   = 13'b0000000100000,
    ST_DIFF  = 13'b0000001000000,
    ST_ABS   = 13'b0000010000000,
    ST_THR   = 13'b0000100000000,
    ST_STEP  = 13'b0001000000000,
    ST_APPLY = 13'b0010000000000,
    ST_FIN   = 13'b0100000000000,
    ST_HOLD  = 13'b1000000000000
  } seq_state_e;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [THR_W-1:0]   threshold;
    logic [GAIN_W-1:0]  fast_gain;
    logic [GAIN_W-1:0]  slow_gain;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic [OUT_W-1:0] filtered_cm;
    logic [OUT_W-1:0] median_cm;
    logic             fast_used;
  } result_t;

endpackage

/* rtl/msm_alu.sv */
// Shared arithmetic unit of the smoother: one multiplier and one add/subtract.
// Depends on msm_pkg for widths and operation codes.
`timescale 1ns / 1ps

module msm_alu (
  input  msm_pkg::alu_op_e               op_i,
  input  logic [msm_pkg::OP_W-1:0]       a_i,
  input  logic [msm_pkg::OP_W-1:0]       b_i,
  output logic [msm_pkg::RES_W-1:0]      res_o
);
  import msm_pkg::*;

  logic [OP_W:0] sum;
  logic [OP_W:0] dif;

  // The top bit of sum is the carry, the top bit of dif is the borrow.
  assign sum = {1'b0, a_i} + {1'b0, b_i};
  assign dif = {1'b0, a_i} - {1'b0, b_i};

  always_comb begin
    case (op_i)
      ALU_MUL: res_o = RES_W'(a_i) * RES_W'(b_i);
      ALU_ADD: res_o = RES_W'(sum);
      ALU_SUB: res_o = RES_W'(dif);
      default: res_o = '0;
    endcase
  end

endmodule

/* rtl/msm_core.sv */
// Sequencer and datapath registers of the smoother; every multiply, compare and
// subtract goes through one msm_alu. Depends on msm_pkg and msm_alu.
`timescale 1ns / 1ps

module msm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [msm_pkg::ECHO_W-1:0]    echo_i,
  input  msm_pkg::cfg_t                 cfg_i,
  input  logic                          ack_i,
  output msm_pkg::core_stat_t           stat_o,
  output msm_pkg::result_t              res_o
);
  import msm_pkg::*;

  seq_state_e state_q, state_d;

  logic [ECHO_W-1:0] echo_q;
  logic [DIST_W-1:0] ring_q [3];
  logic [1:0]        slot_q;
  logic [1:0]        slot_d;
  logic [DIST_W-1:0] smoothed_q;
  logic [DIST_W-1:0] med_q;
  logic [DIST_W-1:0] diffc_q;
  logic [DIST_W-1:0] diff_q;
  logic              le_xy_q;
  logic              le_xz_q;
  logic              up_q;
  logic              fast_q;
  logic [RES_W-1:0]  res_q;

  alu_op_e           alu_op;
  logic [OP_W-1:0]   alu_a;
  logic [OP_W-1:0]   alu_b;
  logic [RES_W-1:0]  alu_res;

  logic              borrow;
  logic [RES_W-1:0]  scaled;
  logic [DIST_W-1:0] dist_sat;
  logic [DIST_W-1:0] med;
  logic [DIST_W-1:0] diff_sel;
  logic [GAIN_W-1:0] gain;
  logic [GAIN_W-1:0] gain_sat;
  logic [DIST_W-1:0] step;
  logic [DIST_W-1:0] next_val;

  msm_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Borrow (or carry) of the previous add/subtract sits just above the operand width.
  assign borrow = res_q[OP_W];

  // Distance from the registered echo product, saturated to the format's top.
  assign scaled   = res_q >> SCALE_SH;
  assign dist_sat = (|(scaled >> DIST_W)) ? '1 : scaled[DIST_W-1:0];

  assign slot_d = (slot_q > 2'd1) ? 2'd0 : slot_q + 2'd1;

  // Median from the three order bits; the last one comes from the unit's registered result.
  always_comb begin
    if (le_xy_q && le_xz_q) begin
      med = !borrow ? ring_q[1] : ring_q[2];
    end else if (!le_xy_q && !borrow) begin
      med = le_xz_q ? ring_q[0] : ring_q[2];
    end else begin
      med = le_xy_q ? ring_q[0] : ring_q[1];
    end
  end

  assign diff_sel = up_q ? diffc_q : res_q[DIST_W-1:0];
  assign gain     = borrow ? cfg_i.fast_gain : cfg_i.slow_gain;
  assign gain_sat = (gain > GAIN_ONE) ? GAIN_ONE : gain;
  assign step     = res_q[GAIN_SH +: DIST_W];

  always_comb begin
    if (up_q) begin
      next_val = res_q[DIST_W] ? '1 : res_q[DIST_W-1:0];
    end else begin
      next_val = borrow ? '0 : res_q[DIST_W-1:0];
    end
  end

  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      ST_MUL: begin
        alu_op = ALU_MUL;
        alu_a  = OP_W'(echo_q);
        alu_b  = OP_W'(cfg_i.scale);
      end
      ST_CXY: begin
        alu_a = OP_W'(ring_q[1]);
        alu_b = OP_W'(ring_q[0]);
      end
      ST_CXZ: begin
        alu_a = OP_W'(ring_q[2]);
        alu_b = OP_W'(ring_q[0]);
      end
      ST_CYZ: begin
        alu_a = OP_W'(ring_q[2]);
        alu_b = OP_W'(ring_q[1]);
      end
      ST_DIFF: begin
        alu_a = OP_W'(med);
        alu_b = OP_W'(smoothed_q);
      end
      ST_ABS: begin
        alu_a = OP_W'(smoothed_q);
        alu_b = OP_W'(med_q);
      end
      ST_THR: begin
        alu_a = OP_W'(cfg_i.threshold);
        alu_b = OP_W'(diff_sel[DIST_W-1 -: DINT_W]);
      end
      ST_STEP: begin
        alu_op = ALU_MUL;
        alu_a  = OP_W'(diff_q);
        alu_b  = OP_W'(gain_sat);
      end
      ST_APPLY: begin
        alu_op = up_q ? ALU_ADD : ALU_SUB;
        alu_a  = OP_W'(smoothed_q);
        alu_b  = OP_W'(step);
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_WR;
      ST_WR:    state_d = ST_CXY;
      ST_CXY:   state_d = ST_CXZ;
      ST_CXZ:   state_d = ST_CYZ;
      ST_CYZ:   state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_ABS;
      ST_ABS:   state_d = ST_THR;
      ST_THR:   state_d = ST_STEP;
      ST_STEP:  state_d = ST_APPLY;
      ST_APPLY: state_d = ST_FIN;
      ST_FIN:   state_d = ST_HOLD;
      ST_HOLD:  if (ack_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_q     <= 2'd0;
      smoothed_q <= '0;
      for (int i = 0; i < 3; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_WR) begin
        slot_q <= slot_d;
        for (int i = 0; i < 3; i++) begin
          if (slot_d == 2'(i)) ring_q[i] <= dist_sat;
        end
      end
      if (state_q == ST_FIN) smoothed_q <= next_val;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= alu_res;
    if (state_q == ST_IDLE && start_i) echo_q <= echo_i;
    if (state_q == ST_CXZ) le_xy_q <= !borrow;
    if (state_q == ST_CYZ) le_xz_q <= !borrow;
    if (state_q == ST_DIFF) med_q <= med;
    if (state_q == ST_ABS) begin
      up_q    <= !borrow;
      diffc_q <= res_q[DIST_W-1:0];
    end
    if (state_q == ST_THR) diff_q <= diff_sel;
    if (state_q == ST_STEP) fast_q <= borrow;
  end

  assign stat_o.ready      = (state_q == ST_IDLE);
  assign stat_o.done       = (state_q == ST_HOLD);
  assign res_o.filtered_cm = OUT_W'(smoothed_q);
  assign res_o.median_cm   = OUT_W'(med_q);
  assign res_o.fast_used   = fast_q;

endmodule

/* rtl/median3_adaptive_smoother_unit.sv */
// Top level of the median-of-three adaptive distance smoother: stream ports,
// configuration registers and the output register. Depends on msm_pkg, msm_core.
//
//   Channel   Direction  Handshake                    Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata: echo_us
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata: filtered_cm, median_cm;
//                                                     tuser: fast_used
//   cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// From one accepted input transaction to the next, an item runs through eleven
// sequencer steps, nine of them through the shared multiply/add/subtract unit and
// two that only load registers, a hand-off state that moves the result to the
// output register once that register can take it, and the idle state to accept.
// Reset is asynchronous and active low; it loads the register defaults and clears
// the sample ring, ring slot and smoothed value. A result waiting on m_axis does
// not stop the next input from being accepted; only a second finished result waits.
`timescale 1ns / 1ps

module median3_adaptive_smoother_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [msm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [14:0] echo_us
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [msm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [16:0] filtered_cm,
                                                              // [33:17] median_cm
  output logic                                m_axis_tuser,   // [0] fast_used
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [msm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [msm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import msm_pkg::*;

  cfg_t       cfg_q;
  core_stat_t stat;
  result_t    core_res;
  result_t    out_q;
  logic       out_valid_q;
  logic       start;
  logic       handoff;

  // Configuration is always accepted; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale     <= SCALE_RST;
      cfg_q.threshold <= THR_RST;
      cfg_q.fast_gain <= FAST_RST;
      cfg_q.slow_gain <= SLOW_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCALE:     cfg_q.scale     <= cfg_data_i[SCALE_W-1:0];
        REG_THRESHOLD: cfg_q.threshold <= cfg_data_i[THR_W-1:0];
        REG_FAST_GAIN: cfg_q.fast_gain <= cfg_data_i[GAIN_W-1:0];
        REG_SLOW_GAIN: cfg_q.slow_gain <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The sequencer takes an item only when it is idle.
  assign s_axis_tready = stat.ready;
  assign start         = s_axis_tvalid && stat.ready;

  // A finished result moves to the output register once that register is free
  // or being emptied in the same cycle.
  assign handoff = stat.done && (!out_valid_q || m_axis_tready);

  msm_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .echo_i  (s_axis_tdata[ECHO_W-1:0]),
    .cfg_i   (cfg_q),
    .ack_i   (handoff),
    .stat_o  (stat),
    .res_o   (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (handoff) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (handoff) out_q <= core_res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.median_cm, out_q.filtered_cm});
  assign m_axis_tuser  = out_q.fast_used;

endmodule

/* rtl/msm_checker.sv */
// Port-level assertions for the smoother top level, attached by the bind below.
// Depends on msm_pkg for the port widths.
`timescale 1ns / 1ps

module msm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [msm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input logic                                m_axis_tuser
);
  import msm_pkg::*;

  // The sequencer is busy straight after it takes an input transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // A new result appears only as the sequencer leaves its hand-off state.
  a_result_from_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while the sequencer was idle");

  // A stalled result keeps its payload.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // Padding above the two distance fields stays zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata >> (2 * OUT_W)) == '0))
    else $error("output padding not zero");

endmodule

bind median3_adaptive_smoother_unit msm_checker u_msm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
